FILE: rtl/core/hssc_pkg.sv
// Package for the heading steer speed controller.
// Holds item structs, mode and register codes, fixed-point angle constants
// and the elaboration-time sine series. No dependencies.
package hssc_pkg;

  localparam int ANGLE_FRACTION_BITS = 6;
  localparam int DEG90  = 90 * (1 << ANGLE_FRACTION_BITS);
  localparam int DEG175 = 175 * (1 << ANGLE_FRACTION_BITS);
  localparam int DEG180 = 180 * (1 << ANGLE_FRACTION_BITS);
  localparam int DEG360 = 360 * (1 << ANGLE_FRACTION_BITS);
  localparam int ACLIP_W = $clog2(DEG90 + 1);

  localparam int SINE_TABLE_ENTRIES_DEF = 256;

  localparam logic [1:0] MODE_TIMEOUT = 2'd0;
  localparam logic [1:0] MODE_HEADING = 2'd1;
  localparam logic [1:0] MODE_PASS    = 2'd2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_TURN_ANGLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEER_SPEED  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STEER_SPEED  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_TIMEOUT  = 3'd4;

  localparam logic [13:0] RST_POINT_TURN_ANGLE = 14'(DEG180);
  localparam logic [14:0] RST_MAX_STEER_SPEED  = 15'(DEG90);
  localparam logic [14:0] RST_MIN_STEER_SPEED  = 15'(6 * (1 << ANGLE_FRACTION_BITS));
  localparam logic [15:0] RST_COMMAND_TIMEOUT  = 16'd2000;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic [14:0]        desired_yaw;
    logic [14:0]        current_yaw;
    logic signed [15:0] desired_drive_speed;
    logic signed [15:0] desired_steer_speed;
    logic [15:0]        rotation_age;
    logic [15:0]        speed_age;
    logic [15:0]        steer_age;
  } hssc_in_t;

  typedef struct packed {
    logic signed [15:0] control_drive_speed;
    logic signed [15:0] control_steer_speed;
    logic               point_turn_warning;
    logic [1:0]         control_mode;
  } hssc_out_t;

  typedef struct packed {
    logic        reverse_enable;
    logic [13:0] point_turn_angle;
    logic [14:0] max_steer_speed;
    logic [14:0] min_steer_speed;
    logic [15:0] command_timeout;
  } hssc_cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] drive;
    logic signed [15:0] steer;
    logic               steer_neg;
    logic               pt_clip;
    logic [ACLIP_W-1:0] a_clip;
  } hssc_head_t;

  // wrap to (-180,180]; input is within two turns of zero
  function automatic logic signed [16:0] wrap180(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (r >= 18'(DEG360)) begin
      r = r - 18'(DEG360);
    end else if (r <= -18'(DEG360)) begin
      r = r + 18'(DEG360);
    end
    if (r > 18'(DEG180)) begin
      r = r - 18'(DEG360);
    end else if (r <= -18'(DEG180)) begin
      r = r + 18'(DEG360);
    end
    return r[16:0];
  endfunction

  // Q0.15 sine of a Q30 angle by a nested Taylor series
  function automatic logic [14:0] sine_q15(input longint x);
    longint x2;
    longint t;
    longint s;
    longint q;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
    s  = (x * t) >>> 30;
    q  = (s + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    if (q < 64'sd0) begin
      q = 64'sd0;
    end
    return q[14:0];
  endfunction

endpackage

FILE: rtl/core/hssc_heading.sv
// Mode select and heading error path: wrap, reverse, point-turn compare,
// sign and clipped angle. Combinational. Depends on hssc_pkg.
module hssc_heading
  import hssc_pkg::*;
(
  input  hssc_in_t   item,
  input  hssc_cfg_t  cfg,
  output hssc_head_t head
);

  logic signed [16:0] diff;
  logic signed [16:0] h0;
  logic signed [16:0] h;
  logic               rev;
  logic signed [15:0] drive_neg;
  logic signed [15:0] drive_dir;
  logic [14:0]        a;
  logic               a_ge_pt;
  logic [ACLIP_W-1:0] a_clip;
  logic               timed_out;

  always_comb begin
    diff = $signed({2'b00, item.desired_yaw}) - $signed({2'b00, item.current_yaw});
    h0 = wrap180({diff[16], diff});
    rev = cfg.reverse_enable && (h0 > 17'(DEG90) || h0 < -17'(DEG90));
    h = rev ? wrap180({h0[16], h0} + 18'(DEG180)) : h0;
    drive_neg = (item.desired_drive_speed == 16'sh8000) ? 16'sh7fff
                                                        : -item.desired_drive_speed;
    drive_dir = rev ? drive_neg : item.desired_drive_speed;
    a = (h < 0) ? 15'(-h) : 15'(h);
    a_ge_pt = a >= 15'(cfg.point_turn_angle);
    a_clip = (a > 15'(DEG90)) ? ACLIP_W'(DEG90) : ACLIP_W'(a);
    timed_out = item.rotation_age > cfg.command_timeout &&
                item.speed_age > cfg.command_timeout;

    head.mode      = MODE_PASS;
    head.drive     = item.desired_drive_speed;
    head.steer     = item.desired_steer_speed;
    head.steer_neg = !(h >= 0 || h < -17'(DEG175));
    head.pt_clip   = 14'(a_clip) >= cfg.point_turn_angle;
    head.a_clip    = a_clip;
    if (timed_out) begin
      head.mode  = MODE_TIMEOUT;
      head.drive = '0;
      head.steer = '0;
    end else if (item.rotation_age < item.steer_age) begin
      head.mode  = MODE_HEADING;
      head.drive = a_ge_pt ? 16'sd0 : drive_dir;
      head.steer = '0;
    end
  end

endmodule

FILE: rtl/core/hssc_sine_rom.sv
// Quarter-sine constant table, Q0.15, entries 0..SINE_TABLE_ENTRIES.
// Built at elaboration from the series in hssc_pkg.
module hssc_sine_rom
  import hssc_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
  input  logic [$clog2(SINE_TABLE_ENTRIES+1)-1:0] idx,
  output logic [14:0]                             entry
);

  logic [14:0] rom [0:SINE_TABLE_ENTRIES];

  for (genvar gi = 0; gi <= SINE_TABLE_ENTRIES; gi++) begin : g_rom
    localparam longint X = (HALF_PI_Q30 * longint'(gi)) / SINE_TABLE_ENTRIES;
    assign rom[gi] = sine_q15(X);
  end

  assign entry = rom[idx];

endmodule

FILE: rtl/core/hssc_finish.sv
// Final steer sign and small-steer rule, builds the result item.
// Combinational. Depends on hssc_pkg.
module hssc_finish
  import hssc_pkg::*;
(
  input  hssc_head_t head,
  input  logic [15:0] mag,
  input  hssc_cfg_t  cfg,
  output hssc_out_t  res
);

  logic signed [15:0] steer_val;
  logic               small_steer;

  always_comb begin
    steer_val = head.steer_neg ? -$signed(mag) : $signed(mag);
    small_steer = mag < {1'b0, cfg.min_steer_speed};

    res.control_drive_speed = head.drive;
    res.control_steer_speed = head.steer;
    res.point_turn_warning  = 1'b0;
    res.control_mode        = head.mode;
    if (head.mode == MODE_HEADING) begin
      res.control_steer_speed = steer_val;
      if (small_steer) begin
        if (head.pt_clip) begin
          res.control_drive_speed = '0;
          res.point_turn_warning  = 1'b1;
        end else begin
          res.control_steer_speed = '0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/heading_steer_speed_controller.sv
// Heading steer speed controller, top level. Uses hssc_pkg, hssc_heading,
// hssc_sine_rom and hssc_finish.
// Throughput: one item per cycle while out_stall is low; five register stages (input, heading,
// table index by reciprocal multiply, sine times max steer, result).
// Reset (rst, synchronous): pipeline emptied, registers to defaults.
module heading_steer_speed_controller
  import hssc_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  hssc_in_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output hssc_out_t              out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int NUM_W  = $clog2(DEG90 * SINE_TABLE_ENTRIES + DEG90 / 2 + 1);
  localparam int SHIFT  = NUM_W + $clog2(DEG90);
  localparam longint RECIP_L = ((longint'(1) <<< SHIFT) + DEG90 - 1) / DEG90;
  localparam int R_W    = $clog2(RECIP_L + 1);
  localparam int PROD_W = NUM_W + R_W;
  localparam logic [R_W-1:0] RECIP = R_W'(RECIP_L);

  hssc_cfg_t cfg;

  logic       v1, v2, v3, v4;
  logic       adv1, adv2, adv3, adv4, adv5;
  hssc_in_t   item1;
  hssc_head_t head2, head3, head4;
  hssc_head_t head_c;
  logic [NUM_W-1:0]  num2;
  logic [NUM_W-1:0]  num_c;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx3;
  logic [14:0]       entry;
  logic [15:0]       mag4;
  logic [15:0]       mag_c;
  hssc_out_t         res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_enable   <= 1'b0;
      cfg.point_turn_angle <= RST_POINT_TURN_ANGLE;
      cfg.max_steer_speed  <= RST_MAX_STEER_SPEED;
      cfg.min_steer_speed  <= RST_MIN_STEER_SPEED;
      cfg.command_timeout  <= RST_COMMAND_TIMEOUT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REVERSE_ENABLE:   cfg.reverse_enable   <= cfg_data[0];
        CFG_POINT_TURN_ANGLE: cfg.point_turn_angle <= cfg_data[13:0];
        CFG_MAX_STEER_SPEED:  cfg.max_steer_speed  <= cfg_data[14:0];
        CFG_MIN_STEER_SPEED:  cfg.min_steer_speed  <= cfg_data[14:0];
        CFG_COMMAND_TIMEOUT:  cfg.command_timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv5 = !out_valid || !out_stall;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  hssc_heading u_heading (
    .item (item1),
    .cfg  (cfg),
    .head (head_c)
  );

  assign num_c = NUM_W'(head_c.a_clip) * NUM_W'(SINE_TABLE_ENTRIES) + NUM_W'(DEG90 / 2);
  assign prod  = PROD_W'(num2) * PROD_W'(RECIP);

  hssc_sine_rom #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_sine_rom (
    .idx   (idx3),
    .entry (entry)
  );

  assign mag_c = 16'((31'(entry) * 31'(cfg.max_steer_speed) + 31'd16384) >> 15);

  hssc_finish u_finish (
    .head (head4),
    .mag  (mag4),
    .cfg  (cfg),
    .res  (res_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      item1 <= in_item;
    end
    if (adv2) begin
      head2 <= head_c;
      num2  <= num_c;
    end
    if (adv3) begin
      head3 <= head2;
      idx3  <= IDX_W'(prod >> SHIFT);
    end
    if (adv4) begin
      head4 <= head3;
      mag4  <= mag_c;
    end
    if (adv5) begin
      out_item <= res_c;
    end
  end

endmodule

FILE: sim/hssc_command_check.sv
// Result checker for heading_steer_speed_controller: watches the item,
// result and register write ports, predicts each result and compares it.
// Depends on hssc_pkg for the item structs, mode and register codes.
module hssc_command_check
  import hssc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  hssc_in_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  hssc_out_t              out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     failures
);

  localparam int SINE_STEPS = 256;
  localparam int TURN_90  = 90 << ANGLE_FRACTION_BITS;
  localparam int TURN_175 = 175 << ANGLE_FRACTION_BITS;
  localparam int TURN_180 = 180 << ANGLE_FRACTION_BITS;
  localparam int TURN_360 = 360 << ANGLE_FRACTION_BITS;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  logic [15:0] quarter_sine [0:SINE_STEPS];
  longint      series_div [0:4] = '{110, 72, 42, 20, 6};

  logic        rev_en;
  logic [13:0] turn_limit;
  logic [14:0] steer_max;
  logic [14:0] steer_min;
  logic [15:0] stale_ms;

  hssc_out_t   commands_due [$];
  int          mismatches = 0;

  initial begin
    longint x, x2, t, s, q;
    for (int i = 0; i <= SINE_STEPS; i++) begin
      x  = (HALF_PI_Q30 * i) / SINE_STEPS;
      x2 = (x * x) >>> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 5; k++) begin
        t = ONE_Q30 - ((x2 * t) >>> 30) / series_div[k];
      end
      s = (x * t) >>> 30;
      q = (s + 64'sd16384) >>> 15;
      if (q > 64'sd32767) q = 64'sd32767;
      if (q < 64'sd0) q = 64'sd0;
      quarter_sine[i] = q[15:0];
    end
  end

  // heading difference folded into (-180, 180]
  function automatic int fold_heading(int v);
    int w;
    w = v % TURN_360;
    if (w > TURN_180) w -= TURN_360;
    if (w <= -TURN_180) w += TURN_360;
    return w;
  endfunction

  function automatic hssc_out_t command_for(hssc_in_t it);
    hssc_out_t r;
    int h, a, sgn, idx, mag, drv, str;
    r   = '0;
    drv = int'(it.desired_drive_speed);
    str = int'(it.desired_steer_speed);
    if (it.rotation_age > stale_ms && it.speed_age > stale_ms) begin
      r.control_mode = MODE_TIMEOUT;
      drv = 0;
      str = 0;
    end else if (it.rotation_age < it.steer_age) begin
      r.control_mode = MODE_HEADING;
      h = fold_heading(int'(it.desired_yaw) - int'(it.current_yaw));
      if (rev_en && (h > TURN_90 || h < -TURN_90)) begin
        h = fold_heading(h + TURN_180);
        drv = (drv == -32768) ? 32767 : -drv;
      end
      a = (h < 0) ? -h : h;
      if (a >= int'(turn_limit)) drv = 0;
      sgn = (h >= 0 || h < -TURN_175) ? 1 : -1;
      if (a > TURN_90) a = TURN_90;
      idx = (a * SINE_STEPS + TURN_90 / 2) / TURN_90;
      mag = int'((longint'(quarter_sine[idx]) * longint'(steer_max) + 64'sd16384) >>> 15);
      str = sgn * mag;
      if (mag < int'(steer_min)) begin
        if (a >= int'(turn_limit)) begin
          drv = 0;
          r.point_turn_warning = 1'b1;
        end else begin
          str = 0;
        end
      end
    end else begin
      r.control_mode = MODE_PASS;
    end
    r.control_drive_speed = 16'(drv);
    r.control_steer_speed = 16'(str);
    return r;
  endfunction

  always @(posedge clk) begin
    hssc_out_t want;
    if (rst) begin
      rev_en     = 1'b0;
      turn_limit = 14'(TURN_180);
      steer_max  = 15'(TURN_90);
      steer_min  = 15'(6 << ANGLE_FRACTION_BITS);
      stale_ms   = 16'd2000;
      commands_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        commands_due.push_back(command_for(in_item));
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_REVERSE_ENABLE:   rev_en = cfg_data[0];
          CFG_POINT_TURN_ANGLE: turn_limit = cfg_data[13:0];
          CFG_MAX_STEER_SPEED:  steer_max = cfg_data[14:0];
          CFG_MIN_STEER_SPEED:  steer_min = cfg_data[14:0];
          CFG_COMMAND_TIMEOUT:  stale_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (commands_due.size() == 0) begin
          $error("result with no item pending: drive %0d steer %0d mode %0d",
                 out_item.control_drive_speed, out_item.control_steer_speed,
                 out_item.control_mode);
          mismatches++;
        end else begin
          want = commands_due.pop_front();
          if (out_item.control_drive_speed !== want.control_drive_speed) begin
            $error("control_drive_speed: expected %0d, got %0d",
                   want.control_drive_speed, out_item.control_drive_speed);
            mismatches++;
          end
          if (out_item.control_steer_speed !== want.control_steer_speed) begin
            $error("control_steer_speed: expected %0d, got %0d",
                   want.control_steer_speed, out_item.control_steer_speed);
            mismatches++;
          end
          if (out_item.point_turn_warning !== want.point_turn_warning) begin
            $error("point_turn_warning: expected %0d, got %0d",
                   want.point_turn_warning, out_item.point_turn_warning);
            mismatches++;
          end
          if (out_item.control_mode !== want.control_mode) begin
            $error("control_mode: expected %0d, got %0d",
                   want.control_mode, out_item.control_mode);
            mismatches++;
          end
        end
      end
    end
    pending  <= commands_due.size();
    failures <= mismatches;
  end

endmodule

FILE: sim/tb.sv
// Top of the heading_steer_speed_controller testbench: clock, reset, register
// phases, directed and random items with bursty sending and receiver stalls.
// Depends on hssc_pkg, the block and hssc_command_check.
module tb;
  import hssc_pkg::*;

  localparam int TURN_90  = 90 << ANGLE_FRACTION_BITS;
  localparam int TURN_175 = 175 << ANGLE_FRACTION_BITS;
  localparam int TURN_360 = 360 << ANGLE_FRACTION_BITS;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 16;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  hssc_in_t               in_item;
  logic                   out_valid;
  logic                   out_stall;
  hssc_out_t              out_item;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     pending;
  int                     failures;

  int burst_left  = 0;
  int pta_now     = 11520;
  int tmo_now     = 2000;
  int stall_style = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  heading_steer_speed_controller dut (.*);
  hssc_command_check chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stalls in stretches: none, light, heavy, or a fixed rhythm
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(8, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("heading_steer_speed_controller: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic hssc_in_t make_cmd(int dy, int cy, int drv, int str,
                                        int ra, int sa, int ta);
    hssc_in_t it;
    it.desired_yaw         = 15'(dy);
    it.current_yaw         = 15'(cy);
    it.desired_drive_speed = 16'(drv);
    it.desired_steer_speed = 16'(str);
    it.rotation_age        = 16'(ra);
    it.speed_age           = 16'(sa);
    it.steer_age           = 16'(ta);
    return it;
  endfunction

  function automatic hssc_in_t heading_cmd(int dy, int cy, int drv);
    return make_cmd(dy, cy, drv, int'($urandom), 0, 0, 1);
  endfunction

  function automatic hssc_in_t random_cmd();
    hssc_in_t it;
    int kind, cy, err, ra, sa, ta;
    kind = $urandom_range(0, 19);
    it.desired_yaw         = 15'($urandom);
    it.current_yaw         = 15'($urandom);
    it.desired_drive_speed = pick_speed();
    it.desired_steer_speed = pick_speed();
    it.rotation_age        = 16'($urandom);
    it.speed_age           = 16'($urandom);
    it.steer_age           = 16'($urandom);
    if (kind < 17 && $urandom_range(0, 9) != 0) begin
      cy = $urandom_range(0, TURN_360 - 1);
      case ($urandom_range(0, 4))
        0: err = $urandom_range(0, TURN_360 - 1);
        1: err = int'($urandom_range(0, 400)) - 200;
        2: err = TURN_90 + int'($urandom_range(0, 200)) - 100;
        3: err = TURN_175 + int'($urandom_range(0, 400)) - 100;
        default: err = pta_now + int'($urandom_range(0, 100)) - 50;
      endcase
      if ($urandom_range(0, 1) == 1) err = -err;
      it.current_yaw = 15'(cy);
      it.desired_yaw = 15'(((cy + err) % TURN_360 + TURN_360) % TURN_360);
    end
    if (kind < 12) begin
      ra = $urandom_range(0, 65534);
      sa = (ra > tmo_now) ? $urandom_range(0, tmo_now) : $urandom_range(0, 65535);
      ta = $urandom_range(ra + 1, 65535);
      it.rotation_age = 16'(ra);
      it.speed_age    = 16'(sa);
      it.steer_age    = 16'(ta);
    end else if (kind < 15) begin
      ra = $urandom_range(0, 65535);
      sa = (ra > tmo_now) ? $urandom_range(0, tmo_now) : $urandom_range(0, 65535);
      ta = $urandom_range(0, ra);
      it.rotation_age = 16'(ra);
      it.speed_age    = 16'(sa);
      it.steer_age    = 16'(ta);
    end else if (kind < 17 && tmo_now < 65535) begin
      it.rotation_age = 16'($urandom_range(tmo_now + 1, 65535));
      it.speed_age    = 16'($urandom_range(tmo_now + 1, 65535));
    end
    return it;
  endfunction

  task automatic send_command(input hssc_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // bits above each register's width carry noise
  task automatic program_controls(input logic rev, input int pta, input int smax,
                                  input int smin, input int tmo);
    write_reg(CFG_REVERSE_ENABLE, {15'($urandom), rev});
    write_reg(CFG_POINT_TURN_ANGLE, {2'($urandom), 14'(pta)});
    write_reg(CFG_MAX_STEER_SPEED, {1'($urandom), 15'(smax)});
    write_reg(CFG_MIN_STEER_SPEED, {1'($urandom), 15'(smin)});
    write_reg(CFG_COMMAND_TIMEOUT, 16'(tmo));
    cfg_write <= 1'b0;
    pta_now = pta;
    tmo_now = tmo;
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 9; phase++) begin
      if (phase != 0) settle();
      case (phase)
        0: begin
          send_command(make_cmd(0, 0, 1234, -1234, 2001, 2001, 0));
          send_command(make_cmd(0, 0, 1234, -1234, 2001, 2000, 65535));
          send_command(make_cmd(TURN_90, 0, -32768, 32767, 100, 7, 100));
          send_command(make_cmd(0, 0, 0, 0, 0, 0, 0));
          send_command(make_cmd(32767, 32767, 32767, -32768, 65535, 65535, 65535));
          send_command(heading_cmd(0, 0, 500));
          send_command(heading_cmd(TURN_90, 0, 500));
          send_command(heading_cmd(0, TURN_90, 500));
          send_command(heading_cmd(2 * TURN_90, 0, 500));
          send_command(heading_cmd(0, TURN_175 + 32, 500));
          send_command(heading_cmd(0, TURN_175, 500));
          send_command(heading_cmd(32767, 0, 500));
          send_command(heading_cmd(0, 32767, -32768));
          send_command(heading_cmd(TURN_360 - 1, 0, 32767));
          send_command(heading_cmd(64, 0, 100));
          send_command(heading_cmd(0, 64, 100));
        end
        1: begin
          program_controls(1'b1, 11520, 5760, 384, 2000);
          send_command(heading_cmd(TURN_90 + TURN_90 / 2, 0, -32768));
          send_command(heading_cmd(0, TURN_90 + TURN_90 / 2, 32767));
          send_command(heading_cmd(TURN_90, 0, 300));
          send_command(heading_cmd(0, TURN_90 + 1, -32768));
          send_command(heading_cmd(2 * TURN_90, 0, -5));
        end
        2: program_controls(1'b1, 0, 0, 32767, 0);
        3: program_controls(1'b0, 16383, 32767, 0, 65535);
        4: program_controls(1'b1, TURN_90, 5760, 384, 100);
        5: program_controls(1'b0, 64, 1000, 500, 3000);
        6: begin
          for (int i = CFG_COMMAND_TIMEOUT + 1; i < (1 << CFG_INDEX_W); i++) begin
            write_reg(CFG_INDEX_W'(i), 16'($urandom));
          end
          cfg_write <= 1'b0;
        end
        7: program_controls(1'($urandom), $urandom_range(0, 16383),
                            $urandom_range(0, 32767), $urandom_range(0, 32767),
                            $urandom_range(0, 65535));
        default: program_controls(1'($urandom), $urandom_range(0, 2000),
                                  $urandom_range(0, 32767), $urandom_range(0, 2000),
                                  $urandom_range(0, 5000));
      endcase
      repeat (ITEMS_PER_PHASE) send_command(random_cmd());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("heading_steer_speed_controller: match");
    end else begin
      $display("heading_steer_speed_controller: mismatch");
    end
    $finish;
  end

endmodule
